/* rtl/timespec_add_sub_compare_unit_assert.svh */
// Assertion macros for the timespec add/sub/compare unit.
// Used by the RTL files that carry concurrent assertions; no other dependency.
`ifndef TIMESPEC_ADD_SUB_COMPARE_UNIT_ASSERT_SVH
`define TIMESPEC_ADD_SUB_COMPARE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSASC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TSASC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSASC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/tsasc_pkg.sv */
// Shared types and constants of the timespec add/sub/compare unit.
// No dependencies.
`default_nettype none
package tsasc_pkg;

	localparam int SEC_BITS_DEF = 32;
	localparam int NS_W         = 33;	// headroom for ns sums and differences

	localparam logic signed [NS_W-1:0] NS_PER_SEC = 33'sd1000000000;
	localparam logic signed [NS_W-1:0] NS_MAX     = 33'sd999999999;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef logic signed [NS_W-1:0] ns_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_t;

	typedef struct packed {
		logic sub;      // operation is a - b
		logic a_neg;    // a seconds negative
		logic b_neg;    // b seconds negative
		logic a_sgn;    // a seconds or ns negative
		logic b_sgn;    // b seconds or ns negative
		cmp_t cmp;
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/tsasc_if.sv */
// Request and result channel interfaces of the timespec add/sub/compare unit.
// Fixed field widths; no dependencies.
`default_nettype none
interface tsasc_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] a_sec;
	logic signed [30:0] a_nsec;
	logic signed [31:0] b_sec;
	logic signed [30:0] b_nsec;

	modport source (output valid, req_type, a_sec, a_nsec, b_sec, b_nsec, input ready);
	modport sink   (input valid, req_type, a_sec, a_nsec, b_sec, b_nsec, output ready);
endinterface

interface tsasc_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_sec;
	logic signed [31:0] res_nsec;
	logic               a_lt_b;
	logic               a_eq_b;
	logic               a_gt_b;

	modport source (output valid, res_sec, res_nsec, a_lt_b, a_eq_b, a_gt_b, input ready);
	modport sink   (input valid, res_sec, res_nsec, a_lt_b, a_eq_b, a_gt_b, output ready);
endinterface
`default_nettype wire

/* rtl/tsasc_front.sv */
// Stage 1: compares, raw seconds sums/differences and ns sums/differences.
// Depends on tsasc_pkg and tsasc_req_if.
`default_nettype none
module tsasc_front
	import tsasc_pkg::*;
#(
	parameter int SEC_BITS = SEC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	tsasc_req_if.sink                req,
	input  wire logic                nxt_ready,
	output logic                     v_s1,
	output ctl_t                     ctl_s1,
	output logic [SEC_BITS-1:0]      sum_s1,
	output logic [SEC_BITS-1:0]      dab_s1,
	output logic [SEC_BITS-1:0]      dba_s1,
	output ns_t                      nsum_s1,
	output ns_t                      nab_s1,
	output ns_t                      nba_s1
);

	logic [SEC_BITS-1:0] ua, ub;
	ns_t                 an, bn;
	logic                s_lt, s_eq, n_lt, n_eq;
	ctl_t                ctl;

	assign ua = SEC_BITS'(req.a_sec);	// sign-extends
	assign ub = SEC_BITS'(req.b_sec);
	assign an = NS_W'(req.a_nsec);
	assign bn = NS_W'(req.b_nsec);

	assign s_lt = req.a_sec < req.b_sec;
	assign s_eq = req.a_sec == req.b_sec;
	assign n_lt = req.a_nsec < req.b_nsec;
	assign n_eq = req.a_nsec == req.b_nsec;

	always_comb begin
		ctl.sub    = (req.req_type == OP_SUB);
		ctl.a_neg  = req.a_sec[31];
		ctl.b_neg  = req.b_sec[31];
		ctl.a_sgn  = req.a_sec[31] | req.a_nsec[30];
		ctl.b_sgn  = req.b_sec[31] | req.b_nsec[30];
		ctl.cmp.lt = s_lt | (s_eq & n_lt);
		ctl.cmp.eq = s_eq & n_eq;
		ctl.cmp.gt = ~s_lt & ~s_eq | (s_eq & ~n_lt & ~n_eq);
	end

	assign req.ready = ~v_s1 | nxt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready) begin
			ctl_s1  <= ctl;
			sum_s1  <= ua + ub;
			dab_s1  <= ua - ub;
			dba_s1  <= ub - ua;
			nsum_s1 <= an + bn;
			nab_s1  <= an - bn;
			nba_s1  <= bn - an;
		end
	end

endmodule
`default_nettype wire

/* rtl/tsasc_carry.sv */
// Stage 2: operand selection and ns carry/borrow into the seconds.
// Depends on tsasc_pkg.
`default_nettype none
module tsasc_carry
	import tsasc_pkg::*;
#(
	parameter int SEC_BITS = SEC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                v_s1,
	input  wire ctl_t                ctl_s1,
	input  wire logic [SEC_BITS-1:0] sum_s1,
	input  wire logic [SEC_BITS-1:0] dab_s1,
	input  wire logic [SEC_BITS-1:0] dba_s1,
	input  wire ns_t                 nsum_s1,
	input  wire ns_t                 nab_s1,
	input  wire ns_t                 nba_s1,
	output logic                     rdy_s1,
	input  wire logic                nxt_ready,
	output logic                     v_s2,
	output ctl_t                     ctl_s2,
	output logic [SEC_BITS-1:0]      sec_s2,
	output ns_t                      ns_s2
);

	logic [SEC_BITS-1:0] sec_sel, delta;
	ns_t                 ns_sel, ns_adj;
	logic                up, dn;

	always_comb begin
		if (ctl_s1.sub) begin
			sec_sel = ctl_s1.cmp.gt ? dab_s1 : dba_s1;
			ns_sel  = ctl_s1.cmp.gt ? nab_s1 : nba_s1;
		end else begin
			sec_sel = sum_s1;
			ns_sel  = nsum_s1;
		end
		up = ~ctl_s1.sub & (ns_sel >= NS_PER_SEC);
		dn = ctl_s1.sub & ns_sel[NS_W-1];
		// one carry or borrow at most
		priority if (up) begin
			delta  = SEC_BITS'(1);
			ns_adj = ns_sel - NS_PER_SEC;
		end else if (dn) begin
			delta  = '1;
			ns_adj = ns_sel + NS_PER_SEC;
		end else begin
			delta  = '0;
			ns_adj = ns_sel;
		end
	end

	assign rdy_s1 = ~v_s2 | nxt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ctl_s2 <= ctl_s1;
			sec_s2 <= sec_sel + delta;
			ns_s2  <= ns_adj;
		end
	end

endmodule
`default_nettype wire

/* rtl/tsasc_sat.sv */
// Stage 3: sign fix-up of reversed subtraction, overflow detect, saturation.
// Depends on tsasc_pkg, tsasc_res_if and the assertion macro header.
`default_nettype none
`include "timespec_add_sub_compare_unit_assert.svh"
module tsasc_sat
	import tsasc_pkg::*;
#(
	parameter int SEC_BITS = SEC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                v_s2,
	input  wire ctl_t                ctl_s2,
	input  wire logic [SEC_BITS-1:0] sec_s2,
	input  wire ns_t                 ns_s2,
	output logic                     rdy_s2,
	tsasc_res_if.source              res
);

	localparam logic [SEC_BITS-1:0] SEC_MAX = {1'b0, {(SEC_BITS-1){1'b1}}};

	logic                rev, sec_nz, sgn, ovf;
	logic [SEC_BITS-1:0] sec_n, sec_f;
	ns_t                 ns_n, ns_f;

	always_comb begin
		rev    = ctl_s2.sub & ~ctl_s2.cmp.gt;
		sec_nz = |sec_s2;
		sec_n  = (rev & sec_nz) ? SEC_BITS'(0) - sec_s2 : sec_s2;
		ns_n   = (rev & ~sec_nz) ? -ns_s2 : ns_s2;
		sgn    = sec_n[SEC_BITS-1];
		if (ctl_s2.sub) begin
			ovf = (ctl_s2.a_neg & ~ctl_s2.b_neg & ~sgn) | (~ctl_s2.a_neg & ctl_s2.b_neg & sgn);
		end else begin
			ovf = (~ctl_s2.a_neg & ~ctl_s2.b_neg & sgn) | (ctl_s2.a_neg & ctl_s2.b_neg & ~sgn);
		end
		priority if (ovf && ctl_s2.a_sgn && ctl_s2.b_sgn) begin
			sec_f = '0;
			ns_f  = '0;
		end else if (ovf) begin
			sec_f = SEC_MAX;
			ns_f  = NS_MAX;
		end else begin
			sec_f = sec_n;
			ns_f  = ns_n;
		end
	end

	assign rdy_s2 = ~res.valid | res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (rdy_s2) begin
			res.valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			res.res_sec  <= sec_f[31:0];
			res.res_nsec <= ns_f[31:0];
			res.a_lt_b   <= ctl_s2.cmp.lt;
			res.a_eq_b   <= ctl_s2.cmp.eq;
			res.a_gt_b   <= ctl_s2.cmp.gt;
		end
	end

	// exactly one ordering flag per result
	`TSASC_ASSERT_IMP(a_flags_onehot, clk, arst_n, res.valid,
		$onehot({res.a_lt_b, res.a_eq_b, res.a_gt_b}), "ordering flags not one-hot")
	// a - a is zero
	`TSASC_ASSERT_IMP(a_sub_eq_zero, clk, arst_n, v_s2 && ctl_s2.sub && ctl_s2.cmp.eq,
		sec_f == '0 && ns_f == '0, "equal subtraction not zero")
	// a - b with a greater never goes negative in seconds
	`TSASC_ASSERT_IMP(a_sub_gt_pos, clk, arst_n, v_s2 && ctl_s2.sub && ctl_s2.cmp.gt,
		!sec_f[SEC_BITS-1], "greater subtraction negative")

endmodule
`default_nettype wire

/* rtl/timespec_add_sub_compare_unit.sv */
// Timespec add/sub/compare unit: usage notes
//
// Channels: req (sink) takes req_type, a_sec/a_nsec, b_sec/b_nsec; res (source)
// returns res_sec/res_nsec and the a_lt_b/a_eq_b/a_gt_b flags. A transfer
// happens on a rising clk edge with valid and ready both high. Every request
// yields exactly one result, in order.
//
// Pipeline: a request passes one register per stage (compare and raw add/sub,
// carry/borrow, negate and saturate); res.valid comes from the last stage.
// Throughput: one transfer per cycle while res.ready stays high; each stage's
// worst path is one or two SEC_BITS-wide carry chains plus selection.
//
// Stall: each stage holds while the one after it is full and blocked; a stage
// with no valid item always loads, so bubbles collapse. req.ready falls only
// when all three stages hold items and res.ready is low. Nothing is dropped or
// repeated under stall.
//
// Reset: arst_n (asynchronous, active low) empties the pipeline; payload
// registers are not reset. No configuration, no state between items.
`default_nettype none
module timespec_add_sub_compare_unit
	import tsasc_pkg::*;
#(
	parameter int SEC_BITS = SEC_BITS_DEF	// seconds arithmetic width, 32..64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsasc_req_if.sink   req,
	tsasc_res_if.source res
);

	// stage 1 -> 2
	logic                v_s1;
	ctl_t                ctl_s1;
	logic [SEC_BITS-1:0] sum_s1, dab_s1, dba_s1;
	ns_t                 nsum_s1, nab_s1, nba_s1;
	logic                rdy_s1;

	// stage 2 -> 3
	logic                v_s2;
	ctl_t                ctl_s2;
	logic [SEC_BITS-1:0] sec_s2;
	ns_t                 ns_s2;
	logic                rdy_s2;

	// compares and all candidate sums/differences
	tsasc_front #(.SEC_BITS(SEC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.nxt_ready (rdy_s1),
		.v_s1      (v_s1),
		.ctl_s1    (ctl_s1),
		.sum_s1    (sum_s1),
		.dab_s1    (dab_s1),
		.dba_s1    (dba_s1),
		.nsum_s1   (nsum_s1),
		.nab_s1    (nab_s1),
		.nba_s1    (nba_s1)
	);

	// pick by op/order, ns carry (add) or borrow (sub) into seconds
	tsasc_carry #(.SEC_BITS(SEC_BITS)) u_carry (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.ctl_s1    (ctl_s1),
		.sum_s1    (sum_s1),
		.dab_s1    (dab_s1),
		.dba_s1    (dba_s1),
		.nsum_s1   (nsum_s1),
		.nab_s1    (nab_s1),
		.nba_s1    (nba_s1),
		.rdy_s1    (rdy_s1),
		.nxt_ready (rdy_s2),
		.v_s2      (v_s2),
		.ctl_s2    (ctl_s2),
		.sec_s2    (sec_s2),
		.ns_s2     (ns_s2)
	);

	// negate reversed difference, detect seconds overflow, saturate; output register
	tsasc_sat #(.SEC_BITS(SEC_BITS)) u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s2   (v_s2),
		.ctl_s2 (ctl_s2),
		.sec_s2 (sec_s2),
		.ns_s2  (ns_s2),
		.rdy_s2 (rdy_s2),
		.res    (res)
	);

endmodule
`default_nettype wire

/* dv/timespec_add_sub_compare_unit_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the timespec add/sub/compare unit: predicts each result from
// the request transfer and compares it with the result transfer, in order.
// Depends on tsasc_pkg and the tsasc_req_if / tsasc_res_if interfaces.
module timespec_add_sub_compare_unit_checker
	import tsasc_pkg::*;
#(
	parameter int SEC_BITS = SEC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	tsasc_req_if  req,
	tsasc_res_if  res,
	output int    fail_count,
	output int    pending,
	output int    checked,
	output int    saturated
);

	localparam longint     NANOS    = 64'sd1000000000;
	localparam logic [63:0] SEC_MASK = {64{1'b1}} >> (64 - SEC_BITS);

	typedef struct {
		logic signed [31:0] res_sec;
		logic signed [31:0] res_nsec;
		logic               lt;
		logic               eq;
		logic               gt;
		logic               sat;	// bookkeeping only, not compared
	} timespec_result_t;

	timespec_result_t ts_expect_q[$];
	int n_fail;
	int n_checked;
	int n_sat;

	function automatic timespec_result_t predict_timespec(
		input logic               op,
		input logic signed [31:0] a_s,
		input logic signed [30:0] a_n,
		input logic signed [31:0] b_s,
		input logic signed [30:0] b_n
	);
		longint           as_i, an_i, bs_i, bn_i, rn;
		logic [63:0]      ua, ub, rs;
		logic             a_neg, b_neg, ovf;
		timespec_result_t r;
		as_i  = a_s;
		an_i  = a_n;
		bs_i  = b_s;
		bn_i  = b_n;
		ua    = as_i & SEC_MASK;
		ub    = bs_i & SEC_MASK;
		r.lt  = (as_i < bs_i) || (as_i == bs_i && an_i < bn_i);
		r.eq  = (as_i == bs_i) && (an_i == bn_i);
		r.gt  = (as_i > bs_i) || (as_i == bs_i && an_i > bn_i);
		a_neg = as_i < 0;
		b_neg = bs_i < 0;
		if (op == OP_ADD) begin
			rs = (ua + ub) & SEC_MASK;
			rn = an_i + bn_i;
			if (rn >= NANOS) begin
				rs = (rs + 64'd1) & SEC_MASK;
				rn = rn - NANOS;
			end
			ovf = (!a_neg && !b_neg && rs[SEC_BITS-1]) || (a_neg && b_neg && !rs[SEC_BITS-1]);
		end else begin
			// magnitude first, sign applied afterwards when a is not greater
			if (r.gt) begin
				rs = (ua - ub) & SEC_MASK;
				rn = an_i - bn_i;
			end else begin
				rs = (ub - ua) & SEC_MASK;
				rn = bn_i - an_i;
			end
			if (rn < 0) begin
				rn = rn + NANOS;
				rs = (rs - 64'd1) & SEC_MASK;
			end
			if (!r.gt) begin
				if (rs != 64'd0)
					rs = (64'd0 - rs) & SEC_MASK;
				else
					rn = -rn;
			end
			ovf = (a_neg && !b_neg && !rs[SEC_BITS-1]) || (!a_neg && b_neg && rs[SEC_BITS-1]);
		end
		if (ovf) begin
			if ((a_neg || an_i < 0) && (b_neg || bn_i < 0)) begin
				rs = 64'd0;
				rn = 0;
			end else begin
				rs = SEC_MASK >> 1;
				rn = NANOS - 1;
			end
		end
		r.res_sec  = rs[31:0];
		r.res_nsec = rn[31:0];
		r.sat      = ovf;
		return r;
	endfunction

	// one line per mismatch, capped so a broken build does not flood the log
	task automatic report_mismatch(input string what, input longint got, input longint want_v);
		if (n_fail < 40)
			$display("mismatch at result %0d, %s: got %0d, expected %0d",
				n_checked, what, got, want_v);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		timespec_result_t want;
		if (!arst_n) begin
			ts_expect_q.delete();
			n_fail    = 0;
			n_checked = 0;
			n_sat     = 0;
		end else begin
			if (req.valid && req.ready) begin
				want = predict_timespec(req.req_type, req.a_sec, req.a_nsec,
					req.b_sec, req.b_nsec);
				if (want.sat)
					n_sat++;
				ts_expect_q.push_back(want);
			end
			if (res.valid && res.ready) begin
				if (ts_expect_q.size() == 0) begin
					report_mismatch("result with no request waiting, res_sec", res.res_sec, 0);
				end else begin
					want = ts_expect_q.pop_front();
					if (res.res_sec !== want.res_sec)
						report_mismatch("res_sec", res.res_sec, want.res_sec);
					if (res.res_nsec !== want.res_nsec)
						report_mismatch("res_nsec", res.res_nsec, want.res_nsec);
					if (res.a_lt_b !== want.lt)
						report_mismatch("a_lt_b", res.a_lt_b, want.lt);
					if (res.a_eq_b !== want.eq)
						report_mismatch("a_eq_b", res.a_eq_b, want.eq);
					if (res.a_gt_b !== want.gt)
						report_mismatch("a_gt_b", res.a_gt_b, want.gt);
				end
				n_checked++;
			end
		end
		fail_count <= n_fail;
		pending    <= ts_expect_q.size();
		checked    <= n_checked;
		saturated  <= n_sat;
	end

endmodule

/* dv/timespec_add_sub_compare_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the timespec add/sub/compare unit testbench: clock, reset, request
// stimulus, result back-pressure and the verdict. Uses tsasc_pkg, the channel
// interfaces and timespec_add_sub_compare_unit_checker.
module timespec_add_sub_compare_unit_tb;
	import tsasc_pkg::*;

	localparam int SEC_BITS    = SEC_BITS_DEF;
	localparam int LIMIT       = 400000;	// far above the slowest legal run
	localparam int HOLD_CYCLES = 60;	// long output stall, fills the pipe
	localparam int DRAIN       = 12;	// idle margin after the last result

	localparam logic signed [31:0] SEC_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SEC_MIN = 32'sh80000000;
	localparam logic signed [30:0] NS_TOP  = 31'sd999999999;
	localparam logic signed [30:0] NS_HI   = 31'sh3fffffff;	// beyond +1e9, raw pattern
	localparam logic signed [30:0] NS_LO   = 31'sh40000000;	// most negative pattern

	logic clk;
	logic arst_n;

	tsasc_req_if req_ch ();
	tsasc_res_if res_ch ();

	int fail_count, pending, checked, saturated;
	int n_add, n_sub;
	int cycles;

	// mode flags; the rx ones are shared with the back-pressure process
	bit tx_quiet;	// sender: no gaps between transfers
	bit rx_quiet;	// receiver: ready held high
	bit rx_hold;	// receiver: one long stall requested

	timespec_add_sub_compare_unit #(
		.SEC_BITS(SEC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	timespec_add_sub_compare_unit_checker #(
		.SEC_BITS(SEC_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a lost result or a stuck handshake ends here.
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results still expected", cycles, pending);
		$display("== FAIL ==");
		$finish;
	end

	// Result side: random ready gaps before each transfer, a quiet mode with
	// ready stuck high, and one long stall on request from the stimulus.
	initial begin : result_sink
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rx_hold) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			gap = rx_quiet ? 0 : $urandom_range(3);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			// ready is high, so the first edge with valid is the transfer
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// One request transfer. Called back to back with no time passing between
	// calls, so valid either stays high with new payload or drops for the gap.
	task automatic send_req(
		input logic               op,
		input logic signed [31:0] a_s,
		input logic signed [30:0] a_n,
		input logic signed [31:0] b_s,
		input logic signed [30:0] b_n
	);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.a_sec    <= a_s;
		req_ch.a_nsec   <= a_n;
		req_ch.b_sec    <= b_s;
		req_ch.b_nsec   <= b_n;
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_SUB)
			n_sub++;
		else
			n_add++;
	endtask

	// Stop offering and wait until every predicted result has been seen.
	// The first edge lets the checker count the transfer that just happened.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Seconds: weighted toward the overflow edges and small values where
	// borrows and sign flips happen; full 32-bit random for the rest.
	function automatic logic signed [31:0] rand_sec();
		logic signed [31:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: v = SEC_MAX;
					1: v = SEC_MIN;
					2: v = 32'sd0;
					3: v = -32'sd1;
					default: v = 32'sd1;
				endcase
			end
			1: v = SEC_MAX - 32'($urandom_range(3));
			2: v = SEC_MIN + 32'($urandom_range(3));
			3, 4, 5: v = 32'($urandom_range(200)) - 32'sd100;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Nanoseconds: mostly in range with either sign, sometimes the limits,
	// sometimes a raw 31-bit pattern that may lie outside +-999999999.
	function automatic logic signed [30:0] rand_nsec();
		logic signed [30:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = NS_TOP;
					1: v = -NS_TOP;
					2: v = 31'sd0;
					default: v = -31'sd1;
				endcase
			end
			1: v = 31'($urandom);
			default: begin
				v = 31'($urandom_range(999999999));
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Random request; a share of them has equal seconds or equal operands so
	// the not-greater subtract paths (ns negate, zero result) come up often.
	task automatic send_random();
		int                 k;
		logic               op;
		logic signed [31:0] a_s, b_s;
		logic signed [30:0] a_n, b_n;
		k   = $urandom_range(99);
		op  = $urandom_range(1) ? OP_SUB : OP_ADD;
		a_s = rand_sec();
		a_n = rand_nsec();
		if (k < 15)
			b_s = a_s;
		else if (k < 20)
			b_s = a_s + ($urandom_range(1) ? 32'sd1 : -32'sd1);
		else
			b_s = rand_sec();
		b_n = (k < 8) ? a_n : rand_nsec();
		send_req(op, a_s, a_n, b_s, b_n);
	endtask

	initial begin : stimulus
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold  = 1'b0;
		n_add    = 0;
		n_sub    = 0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= OP_ADD;
		req_ch.a_sec    <= '0;
		req_ch.a_nsec   <= '0;
		req_ch.b_sec    <= '0;
		req_ch.b_nsec   <= '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, carries, both saturation targets, carry into
		// overflow, equal operands, ns negate on zero seconds, borrows,
		// out-of-range ns patterns.
		send_req(OP_ADD, 32'sd0, 31'sd0, 32'sd0, 31'sd0);
		send_req(OP_ADD, SEC_MAX, NS_TOP, SEC_MAX, NS_TOP);
		send_req(OP_ADD, SEC_MIN, -NS_TOP, SEC_MIN, -NS_TOP);
		send_req(OP_ADD, 32'sd5, NS_TOP, 32'sd7, NS_TOP);
		send_req(OP_ADD, SEC_MAX, NS_TOP, 32'sd0, 31'sd1);
		send_req(OP_ADD, -32'sd1, -NS_TOP, 32'sd0, -31'sd1);
		send_req(OP_ADD, SEC_MIN, 31'sd0, -32'sd1, 31'sd0);
		send_req(OP_ADD, -32'sd1, -NS_TOP, 32'sd1, NS_TOP);
		send_req(OP_SUB, 32'sd3, 31'sd500, 32'sd3, 31'sd500);
		send_req(OP_SUB, 32'sd3, 31'sd100, 32'sd3, 31'sd900);
		send_req(OP_SUB, 32'sd2, 31'sd900, 32'sd5, 31'sd100);
		send_req(OP_SUB, 32'sd9, 31'sd100, 32'sd4, 31'sd900);
		send_req(OP_SUB, SEC_MIN, 31'sd0, 32'sd1, 31'sd0);
		send_req(OP_SUB, SEC_MAX, 31'sd0, -32'sd1, 31'sd0);
		send_req(OP_SUB, SEC_MIN, -31'sd5, 32'sd0, -31'sd5);
		send_req(OP_SUB, SEC_MAX, NS_TOP, SEC_MIN, -NS_TOP);
		send_req(OP_SUB, SEC_MIN, -NS_TOP, SEC_MAX, NS_TOP);
		send_req(OP_SUB, 32'sd0, 31'sd0, 32'sd0, 31'sd1);
		send_req(OP_SUB, -32'sd7, -31'sd300, -32'sd7, -31'sd300);
		send_req(OP_ADD, 32'sd0, NS_HI, 32'sd0, NS_HI);
		send_req(OP_ADD, 32'sd0, NS_LO, 32'sd0, NS_LO);
		send_req(OP_SUB, 32'sd0, NS_LO, 32'sd0, NS_HI);

		repeat (300) send_random();

		// Long output stall while the sender keeps pushing at full rate:
		// the pipe fills and req.ready has to drop.
		tx_quiet = 1'b1;
		rx_hold  = 1'b1;
		repeat (40) send_random();
		tx_quiet = 1'b0;

		// Sender pause with the pipe drained completely.
		wait_drained();

		// Back to back on both sides.
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		repeat (150) send_random();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		repeat (488) send_random();

		wait_drained();
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d requests (%0d add, %0d subtract), %0d results compared",
			n_add + n_sub, n_add, n_sub, checked);
		$display("%0d saturated results, one %0d-cycle output stall, one full drain pause",
			saturated, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
